FILE: rtl/cfpc_pkg.sv
// Shared constants, types and register codes of the complex field pixel colorizer.
// Depends on nothing; every other file imports it.
package cfpc_pkg;

   // Number formats
   localparam int FRAC_BITS  = 16;
   localparam int NORM_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int WORD_W     = DATA_W + 1;
   localparam int NORM_W     = NORM_BITS + 1;
   localparam int MAG_W      = DATA_W;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int SQ_W       = 2 * DATA_W - 1 - FRAC_BITS;
   localparam int PAIR_W     = SQ_W + 1;
   localparam int SUM_W      = SQ_W + 3;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int NUM_PARTS  = 6;
   localparam int RGB_W      = NUM_CH * CH_W;
   localparam int WPROD_W    = NORM_W + CH_W;
   localparam int ACC_W      = WPROD_W + 1;
   localparam int MODE_W     = 2;
   localparam int MASK_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Pipeline depths
   localparam int FRONT_LAT = 4;
   localparam int NORM_LAT  = NORM_BITS + 3;
   localparam int BACK_LAT  = 2;
   localparam int PIPE_LAT  = FRONT_LAT + NORM_LAT + BACK_LAT;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic [NORM_W-1:0]        norm_type;

   localparam sample_type Q_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
   localparam norm_type   NORM_ONE = norm_type'(1) << NORM_BITS;
   localparam logic [CH_W-1:0] CH_MAX = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_X, MODE_Y, MODE_Z, MODE_INTENSITY
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DISPLAY_MODE, REG_SHOW_MASK, REG_REAL_LOW, REG_REAL_HIGH,
      REG_IMAG_LOW, REG_IMAG_HIGH, REG_REAL_RGB, REG_IMAG_RGB
   } csr_index_type;

   // Register reset values
   localparam mode_type          RST_DISPLAY_MODE = MODE_X;
   localparam logic [MASK_W-1:0] RST_SHOW_MASK    = 2'b11;
   localparam sample_type        RST_LOW          = -32'sd6553600;
   localparam sample_type        RST_HIGH         = 32'sd6553600;
   localparam logic [RGB_W-1:0]  RST_REAL_RGB     = 24'hFF0000;
   localparam logic [RGB_W-1:0]  RST_IMAG_RGB     = 24'h0000FF;

   // Selected component carried through the front stages
   typedef struct packed {
      logic       intensity;
      sample_type re;
      sample_type im;
   } sel_type;

endpackage

FILE: rtl/cfpc_channels.sv
// Request and response channel interfaces of the complex field pixel colorizer.
// Depends on cfpc_pkg.
interface cfpc_req_if import cfpc_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type ex_re;
   sample_type ex_im;
   sample_type ey_re;
   sample_type ey_im;
   sample_type ez_re;
   sample_type ez_im;

   modport source (output valid, ex_re, ex_im, ey_re, ey_im, ez_re, ez_im, input ready);
   modport sink   (input valid, ex_re, ex_im, ey_re, ey_im, ez_re, ez_im, output ready);
endinterface

interface cfpc_rsp_if import cfpc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: rtl/cfpc_norm.sv
// Pipelined normalizer: (v - low) / (high - low) clamped to [0, 1], one quotient
// bit per stage. Depends on cfpc_pkg; all stages advance together on enable.
module cfpc_norm import cfpc_pkg::*; (
   input  logic       clock,
   input  logic       enable,
   input  sample_type value,
   input  sample_type low,
   input  sample_type high,
   output norm_type   result
);

   logic signed [WORD_W-1:0] d_ff, w_ff;
   logic [WORD_W-1:0]        ad_ff, aw2_ff, ad_in, aw_in;
   logic                     fix2_ff, one2_ff, fix2_in, one2_in;
   logic [WORD_W-1:0]        r3_ff, aw3_ff;
   logic                     fix3_ff, one3_ff;

   logic [WORD_W-1:0]    rem_ff [NORM_BITS];
   logic [WORD_W-1:0]    aw_ff  [NORM_BITS];
   logic [NORM_BITS-1:0] quo_ff [NORM_BITS];
   logic                 fix_ff [NORM_BITS];
   logic                 one_ff [NORM_BITS];

   logic [WORD_W-1:0]    src_rem [NORM_BITS];
   logic [WORD_W-1:0]    src_aw  [NORM_BITS];
   logic [NORM_BITS-1:0] src_quo [NORM_BITS];
   logic                 src_fix [NORM_BITS];
   logic                 src_one [NORM_BITS];
   logic [WORD_W-1:0]    rem_in  [NORM_BITS];
   logic [NORM_BITS-1:0] quo_in  [NORM_BITS];
   logic [WORD_W:0]      shifted [NORM_BITS];

   // Classify the interval: zero width, zero offset or opposite signs settle it
   always_comb begin
      logic dz, wz, mism;
      dz      = (d_ff == '0);
      wz      = (w_ff == '0);
      mism    = d_ff[WORD_W-1] != w_ff[WORD_W-1];
      fix2_in = wz | dz | mism;
      one2_in = wz & ~d_ff[WORD_W-1] & ~dz;
      ad_in   = d_ff[WORD_W-1] ? WORD_W'(-d_ff) : WORD_W'(d_ff);
      aw_in   = w_ff[WORD_W-1] ? WORD_W'(-w_ff) : WORD_W'(w_ff);
   end

   // Feed each divide stage from the one before it
   always_comb begin
      for (int k = 0; k < NORM_BITS; k++) begin
         if (k == 0) begin
            src_rem[k] = r3_ff;
            src_aw[k]  = aw3_ff;
            src_quo[k] = '0;
            src_fix[k] = fix3_ff;
            src_one[k] = one3_ff;
         end else begin
            src_rem[k] = rem_ff[k-1];
            src_aw[k]  = aw_ff[k-1];
            src_quo[k] = quo_ff[k-1];
            src_fix[k] = fix_ff[k-1];
            src_one[k] = one_ff[k-1];
         end
         shifted[k] = {src_rem[k], 1'b0};
         if (shifted[k] >= {1'b0, src_aw[k]}) begin
            rem_in[k] = WORD_W'(shifted[k] - {1'b0, src_aw[k]});
            quo_in[k] = {src_quo[k][NORM_BITS-2:0], 1'b1};
         end else begin
            rem_in[k] = WORD_W'(shifted[k]);
            quo_in[k] = {src_quo[k][NORM_BITS-2:0], 1'b0};
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff    <= {value[DATA_W-1], value} - {low[DATA_W-1], low};
         w_ff    <= {high[DATA_W-1], high} - {low[DATA_W-1], low};
         ad_ff   <= ad_in;
         aw2_ff  <= aw_in;
         fix2_ff <= fix2_in;
         one2_ff <= one2_in;
         // quotient of one or more clamps to one
         r3_ff   <= ad_ff;
         aw3_ff  <= aw2_ff;
         fix3_ff <= fix2_ff | (ad_ff >= aw2_ff);
         one3_ff <= fix2_ff ? one2_ff : 1'b1;
         for (int k = 0; k < NORM_BITS; k++) begin
            rem_ff[k] <= rem_in[k];
            aw_ff[k]  <= src_aw[k];
            quo_ff[k] <= quo_in[k];
            fix_ff[k] <= src_fix[k];
            one_ff[k] <= src_one[k];
         end
      end
   end

   assign result = fix_ff[NORM_BITS-1]
                 ? (one_ff[NORM_BITS-1] ? NORM_ONE : norm_type'(0))
                 : {1'b0, quo_ff[NORM_BITS-1]};

endmodule

FILE: rtl/complex_field_pixel_colorizer.sv
// Top level of the complex field pixel colorizer: registers, component select,
// intensity sum, two normalizers and color weighting. Depends on cfpc_pkg,
// cfpc_channels and cfpc_norm.
// Depth: PIPE_LAT = 25 register stages; the valid bit of an accepted request
// moves through them alongside its data and marks the response on the last one.
// Throughput: one request per cycle while not stalled; every stage moves on the
// same enable, so a stalled response holds the whole pipeline and adds no bubble.
// Reset: synchronous, clears the valid pipeline and loads the register defaults.
module complex_field_pixel_colorizer import cfpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cfpc_req_if.sink              req_chan,
   cfpc_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   mode_type          mode_ff;
   logic [MASK_W-1:0] mask_ff;
   sample_type        re_lo_ff, re_hi_ff, im_lo_ff, im_hi_ff;
   logic [RGB_W-1:0]  real_rgb_ff, imag_rgb_ff;

   logic                en;
   logic [PIPE_LAT-1:0] vld_ff;

   sample_type        parts [NUM_PARTS];
   logic [MAG_W-1:0]  mag_in [NUM_PARTS];
   logic [MAG_W-1:0]  mag_ff [NUM_PARTS];
   logic [SQ_W-1:0]   sq_ff  [NUM_PARTS];
   logic [PAIR_W-1:0] pair_ff [NUM_PARTS/2];
   logic [PROD_W-1:0] prod   [NUM_PARTS];
   sel_type           sel_in;
   sel_type           sel_ff [FRONT_LAT-1];
   sample_type        re4_ff, im4_ff, re4_in, im4_in;
   logic [SUM_W-1:0]  total;
   norm_type          rn, nim;
   logic [CH_W-1:0]   wr [NUM_CH];
   logic [CH_W-1:0]   wi [NUM_CH];
   logic [WPROD_W-1:0] pr_ff [NUM_CH];
   logic [WPROD_W-1:0] pi_ff [NUM_CH];
   logic [ACC_W-1:0]  acc [NUM_CH];
   logic [CH_W-1:0]   color_in [NUM_CH];
   logic [CH_W-1:0]   color_ff [NUM_CH];

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= RST_DISPLAY_MODE;
         mask_ff      <= RST_SHOW_MASK;
         re_lo_ff     <= RST_LOW;
         re_hi_ff     <= RST_HIGH;
         im_lo_ff     <= RST_LOW;
         im_hi_ff     <= RST_HIGH;
         real_rgb_ff  <= RST_REAL_RGB;
         imag_rgb_ff  <= RST_IMAG_RGB;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_DISPLAY_MODE: mode_ff      <= mode_type'(csr_wdata[MODE_W-1:0]);
            REG_SHOW_MASK:    mask_ff      <= csr_wdata[MASK_W-1:0];
            REG_REAL_LOW:     re_lo_ff     <= sample_type'(csr_wdata[DATA_W-1:0]);
            REG_REAL_HIGH:    re_hi_ff     <= sample_type'(csr_wdata[DATA_W-1:0]);
            REG_IMAG_LOW:     im_lo_ff     <= sample_type'(csr_wdata[DATA_W-1:0]);
            REG_IMAG_HIGH:    im_hi_ff     <= sample_type'(csr_wdata[DATA_W-1:0]);
            REG_REAL_RGB:     real_rgb_ff  <= csr_wdata[RGB_W-1:0];
            REG_IMAG_RGB:     imag_rgb_ff  <= csr_wdata[RGB_W-1:0];
         endcase
      end
   end

   // Advance when the response register is free or being taken
   assign en             = ~vld_ff[PIPE_LAT-1] | rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_chan.valid};
      end
   end

   // Stage 1: magnitudes and component select
   always_comb begin
      parts[0] = req_chan.ex_re;
      parts[1] = req_chan.ex_im;
      parts[2] = req_chan.ey_re;
      parts[3] = req_chan.ey_im;
      parts[4] = req_chan.ez_re;
      parts[5] = req_chan.ez_im;
      for (int i = 0; i < NUM_PARTS; i++) begin
         mag_in[i] = parts[i][DATA_W-1] ? MAG_W'(-parts[i]) : MAG_W'(parts[i]);
      end
      sel_in.intensity = (mode_ff == MODE_INTENSITY);
      unique case (mode_ff)
         MODE_X: begin
            sel_in.re = req_chan.ex_re;
            sel_in.im = req_chan.ex_im;
         end
         MODE_Y: begin
            sel_in.re = req_chan.ey_re;
            sel_in.im = req_chan.ey_im;
         end
         MODE_Z: begin
            sel_in.re = req_chan.ez_re;
            sel_in.im = req_chan.ez_im;
         end
         MODE_INTENSITY: begin
            sel_in.re = req_chan.ex_re;
            sel_in.im = req_chan.ex_im;
         end
      endcase
   end

   // Stage 2 squares, stage 3 pair sums, stage 4 saturated total or selected component
   always_comb begin
      for (int i = 0; i < NUM_PARTS; i++) begin
         prod[i] = PROD_W'(mag_ff[i]) * PROD_W'(mag_ff[i]);
      end
      total = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]) + SUM_W'(pair_ff[2]);
      if (sel_ff[FRONT_LAT-2].intensity) begin
         re4_in = (total > SUM_W'(Q_MAX)) ? Q_MAX : sample_type'(total[DATA_W-1:0]);
         im4_in = '0;
      end else begin
         re4_in = sel_ff[FRONT_LAT-2].re;
         im4_in = sel_ff[FRONT_LAT-2].im;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sel_ff[0] <= sel_in;
         for (int s = 1; s < FRONT_LAT-1; s++) begin
            sel_ff[s] <= sel_ff[s-1];
         end
         for (int i = 0; i < NUM_PARTS; i++) begin
            mag_ff[i] <= mag_in[i];
            sq_ff[i]  <= prod[i][FRAC_BITS +: SQ_W];
         end
         for (int i = 0; i < NUM_PARTS/2; i++) begin
            pair_ff[i] <= PAIR_W'(sq_ff[2*i]) + PAIR_W'(sq_ff[2*i+1]);
         end
         re4_ff <= re4_in;
         im4_ff <= im4_in;
      end
   end

   // Normalize both parts
   cfpc_norm u_norm_re (
      .clock  (clock),
      .enable (en),
      .value  (re4_ff),
      .low    (re_lo_ff),
      .high   (re_hi_ff),
      .result (rn)
   );

   cfpc_norm u_norm_im (
      .clock  (clock),
      .enable (en),
      .value  (im4_ff),
      .low    (im_lo_ff),
      .high   (im_hi_ff),
      .result (nim)
   );

   // Weight, sum, drop fraction and saturate each channel; red sits on top
   always_comb begin
      logic [ACC_W-NORM_BITS-1:0] whole;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         wr[ch] = mask_ff[0] ? real_rgb_ff[(NUM_CH-1-ch)*CH_W +: CH_W] : '0;
         wi[ch] = mask_ff[1] ? imag_rgb_ff[(NUM_CH-1-ch)*CH_W +: CH_W] : '0;
         acc[ch] = ACC_W'(pr_ff[ch]) + ACC_W'(pi_ff[ch]);
         whole   = acc[ch][ACC_W-1:NORM_BITS];
         color_in[ch] = (whole > (ACC_W-NORM_BITS)'(CH_MAX)) ? CH_MAX : whole[CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            pr_ff[ch]    <= WPROD_W'(rn) * WPROD_W'(wr[ch]);
            pi_ff[ch]    <= WPROD_W'(nim) * WPROD_W'(wi[ch]);
            color_ff[ch] <= color_in[ch];
         end
      end
   end

   assign rsp_chan.valid = vld_ff[PIPE_LAT-1];
   assign rsp_chan.red   = color_ff[0];
   assign rsp_chan.green = color_ff[1];
   assign rsp_chan.blue  = color_ff[2];

   // An accepted request shows up in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted request missing from first stage");

   // Hold every stage while the response is stalled
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   // Saturated intensity never goes negative
   a_intensity_pos: assert property (@(posedge clock) disable iff (reset)
      vld_ff[FRONT_LAT-1] && $past(en) && $past(sel_ff[FRONT_LAT-2].intensity)
      |-> !re4_ff[DATA_W-1])
      else $error("intensity went negative");

   // Normalized values stay within one
   a_norm_clamp: assert property (@(posedge clock) disable iff (reset)
      vld_ff[FRONT_LAT+NORM_LAT-1] |-> (rn <= NORM_ONE) && (nim <= NORM_ONE))
      else $error("normalized value above one");

endmodule

FILE: tb/sv/cfpc_checker.sv
// Response checker for the complex field pixel colorizer testbench.
// Depends on cfpc_pkg and cfpc_channels; watches both channels and the register port.
`timescale 1ns / 1ps
module cfpc_checker import cfpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cfpc_req_if                   req,
   cfpc_rsp_if                   rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   // Shadow copy of the view registers
   mode_type          view_mode;
   logic [MASK_W-1:0] view_mask;
   sample_type        re_lo, re_hi, im_lo, im_hi;
   logic [RGB_W-1:0]  re_rgb, im_rgb;

   pixel_type  expected_pixels [$];
   pixel_type  got, want;
   sample_type parts [NUM_PARTS];

   initial mismatches = 0;

   task automatic report_mismatch(input string what);
      $display("%0t ns: pixel mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Truncated square of one part, FRAC_BITS fraction bits kept
   function automatic longint unsigned square_part(input longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      return (m * m) >> FRAC_BITS;
   endfunction

   // Map v onto [0,1] against lo..hi, rounded toward zero and clamped
   function automatic norm_type scale_part(input longint v, input longint lo, input longint hi);
      longint d, w;
      longint unsigned ad, aw, q;
      d = v - lo;
      w = hi - lo;
      if (w == 0) return (v > lo) ? NORM_ONE : norm_type'(0);
      if (d == 0) return norm_type'(0);
      if ((d < 0) != (w < 0)) return norm_type'(0);
      ad = (d < 0) ? -d : d;
      aw = (w < 0) ? -w : w;
      q = (ad << NORM_BITS) / aw;
      return (q > NORM_ONE) ? NORM_ONE : norm_type'(q);
   endfunction

   function automatic pixel_type colorize(input sample_type p [NUM_PARTS]);
      longint          re, im;
      longint unsigned total, acc;
      norm_type        rn, inn;
      logic [CH_W-1:0] wr, wi;
      logic [CH_W-1:0] level [NUM_CH];
      pixel_type       px;
      // Pick the component, or fold all six parts into the intensity
      case (view_mode)
         MODE_X: begin re = p[0]; im = p[1]; end
         MODE_Y: begin re = p[2]; im = p[3]; end
         MODE_Z: begin re = p[4]; im = p[5]; end
         default: begin
            total = 0;
            for (int i = 0; i < NUM_PARTS; i++) total += square_part(p[i]);
            re = (total > longint'(Q_MAX)) ? longint'(Q_MAX) : longint'(total);
            im = 0;
         end
      endcase
      rn  = scale_part(re, re_lo, re_hi);
      inn = scale_part(im, im_lo, im_hi);
      // Weight each enabled part, drop the fraction, saturate
      for (int ch = 0; ch < NUM_CH; ch++) begin
         wr  = re_rgb[(NUM_CH-1-ch)*CH_W +: CH_W];
         wi  = im_rgb[(NUM_CH-1-ch)*CH_W +: CH_W];
         acc = 0;
         if (view_mask[0]) acc += longint'(rn) * wr;
         if (view_mask[1]) acc += longint'(inn) * wi;
         acc = acc >> NORM_BITS;
         level[ch] = (acc > CH_MAX) ? CH_MAX : acc[CH_W-1:0];
      end
      px.red   = level[0];
      px.green = level[1];
      px.blue  = level[2];
      return px;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         view_mode = RST_DISPLAY_MODE;
         view_mask = RST_SHOW_MASK;
         re_lo     = RST_LOW;
         re_hi     = RST_HIGH;
         im_lo     = RST_LOW;
         im_hi     = RST_HIGH;
         re_rgb    = RST_REAL_RGB;
         im_rgb    = RST_IMAG_RGB;
         expected_pixels.delete();
         outstanding <= 0;
      end else begin
         // Track register writes
         if (csr_we) begin
            case (csr_index)
               REG_DISPLAY_MODE: view_mode = mode_type'(csr_wdata[MODE_W-1:0]);
               REG_SHOW_MASK:    view_mask = csr_wdata[MASK_W-1:0];
               REG_REAL_LOW:     re_lo     = sample_type'(csr_wdata);
               REG_REAL_HIGH:    re_hi     = sample_type'(csr_wdata);
               REG_IMAG_LOW:     im_lo     = sample_type'(csr_wdata);
               REG_IMAG_HIGH:    im_hi     = sample_type'(csr_wdata);
               REG_REAL_RGB:     re_rgb    = csr_wdata[RGB_W-1:0];
               REG_IMAG_RGB:     im_rgb    = csr_wdata[RGB_W-1:0];
               default: ;
            endcase
         end
         // Predict the pixel of each accepted request
         if (req.valid && req.ready) begin
            parts[0] = req.ex_re;
            parts[1] = req.ex_im;
            parts[2] = req.ey_re;
            parts[3] = req.ey_im;
            parts[4] = req.ez_re;
            parts[5] = req.ez_im;
            expected_pixels.push_back(colorize(parts));
         end
         // Compare each accepted response with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            got = {rsp.red, rsp.green, rsp.blue};
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("response %0d/%0d/%0d with no request waiting",
                                         got.red, got.green, got.blue));
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red)
                  report_mismatch($sformatf("red got %0d, expected %0d", got.red, want.red));
               if (got.green !== want.green)
                  report_mismatch($sformatf("green got %0d, expected %0d",
                                            got.green, want.green));
               if (got.blue !== want.blue)
                  report_mismatch($sformatf("blue got %0d, expected %0d", got.blue, want.blue));
            end
         end
         outstanding <= expected_pixels.size();
      end
   end

endmodule

FILE: tb/sv/complex_field_pixel_colorizer_test.sv
// Top of the complex field pixel colorizer testbench: clock, reset, register setup,
// request and response traffic and the verdict. Depends on cfpc_pkg, cfpc_channels,
// cfpc_checker and the block itself.
`timescale 1ns / 1ps
module complex_field_pixel_colorizer_test;
   import cfpc_pkg::*;

   typedef struct packed {
      sample_type ex_re;
      sample_type ex_im;
      sample_type ey_re;
      sample_type ey_im;
      sample_type ez_re;
      sample_type ez_im;
   } field_sample_type;

   typedef struct {
      mode_type          mode;
      logic [MASK_W-1:0] mask;
      sample_type        re_lo;
      sample_type        re_hi;
      sample_type        im_lo;
      sample_type        im_hi;
      logic [RGB_W-1:0]  real_rgb;
      logic [RGB_W-1:0]  imag_rgb;
   } view_settings_type;

   localparam sample_type Q_MIN      = ~Q_MAX;
   localparam sample_type Q_ONE      = 32'sd65536;
   localparam int         HOLD_CYCLES = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    mismatches;
   int                    outstanding;
   logic                  no_gaps = 1'b0;
   logic                  backpressure_armed = 1'b0;

   cfpc_req_if req_chan();
   cfpc_rsp_if rsp_chan();

   complex_field_pixel_colorizer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cfpc_checker pixel_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   initial begin
      #4000000;
      $display("complex_field_pixel_colorizer_test: FAIL");
      $finish;
   end

   // Response side: random stalls, one long hold-off when armed
   initial begin : pixel_sink
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (backpressure_armed && !held) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (no_gaps) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= 11);
         end
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_sample(input field_sample_type s);
      while (!no_gaps && $urandom_range(99) < 11) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ex_re <= s.ex_re;
      req_chan.ex_im <= s.ex_im;
      req_chan.ey_re <= s.ey_re;
      req_chan.ey_im <= s.ey_im;
      req_chan.ez_re <= s.ez_re;
      req_chan.ez_im <= s.ez_im;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stop offering and wait until every predicted pixel has come back
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input view_settings_type v);
      write_reg(REG_DISPLAY_MODE, CSR_DATA_W'(v.mode));
      write_reg(REG_SHOW_MASK,    CSR_DATA_W'(v.mask));
      write_reg(REG_REAL_LOW,     v.re_lo);
      write_reg(REG_REAL_HIGH,    v.re_hi);
      write_reg(REG_IMAG_LOW,     v.im_lo);
      write_reg(REG_IMAG_HIGH,    v.im_hi);
      write_reg(REG_REAL_RGB,     CSR_DATA_W'(v.real_rgb));
      write_reg(REG_IMAG_RGB,     CSR_DATA_W'(v.imag_rgb));
      csr_we <= 1'b0;
   endtask

   // Value near or inside lo..hi, with extremes and plain noise mixed in
   function automatic sample_type pick_part(input sample_type lo, input sample_type hi);
      longint a, b;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      case ($urandom_range(9))
         0: return sample_type'($urandom);
         1: return $urandom_range(1) ? Q_MAX : Q_MIN;
         2: return lo;
         3: return hi;
         4: return sample_type'(a - 1 - $urandom_range(255));
         5: return sample_type'(b + 1 + $urandom_range(255));
         default: return sample_type'(a + longint'({$urandom, $urandom} % (b - a + 1)));
      endcase
   endfunction

   // Part for intensity: magnitudes spread over the whole range
   function automatic sample_type pick_power_part();
      if ($urandom_range(9) == 0) return $urandom_range(1) ? Q_MAX : Q_MIN;
      return sample_type'($urandom) >>> $urandom_range(31);
   endfunction

   function automatic void pick_bounds(output sample_type lo, output sample_type hi);
      int     shape;
      longint base, top;
      shape = $urandom_range(7);
      base  = sample_type'($urandom) >>> $urandom_range(31);
      top   = base + longint'($urandom >> $urandom_range(31));
      if (top > longint'(Q_MAX)) top = Q_MAX;
      case (shape)
         0: begin lo = Q_MIN; hi = Q_MAX; end
         1: begin lo = sample_type'(base); hi = sample_type'(base); end
         2: begin lo = sample_type'(top); hi = sample_type'(base); end
         default: begin lo = sample_type'(base); hi = sample_type'(top); end
      endcase
   endfunction

   function automatic logic [RGB_W-1:0] pick_rgb();
      case ($urandom_range(3))
         0: return '1;
         1: return '0;
         default: return RGB_W'($urandom);
      endcase
   endfunction

   function automatic view_settings_type random_settings(input mode_type m);
      view_settings_type v;
      v.mode = m;
      v.mask = MASK_W'($urandom_range(3));
      pick_bounds(v.re_lo, v.re_hi);
      pick_bounds(v.im_lo, v.im_hi);
      // Intensity is never negative: half the time aim the real range at it
      if (m == MODE_INTENSITY && $urandom_range(1)) begin
         v.re_lo = sample_type'($urandom >> $urandom_range(8, 31));
         v.re_hi = Q_MAX >>> $urandom_range(31);
      end
      v.real_rgb = pick_rgb();
      v.imag_rgb = pick_rgb();
      return v;
   endfunction

   function automatic field_sample_type random_sample(input view_settings_type v);
      field_sample_type s;
      s = field_sample_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(9) == 0) return s;
      case (v.mode)
         MODE_X: begin
            s.ex_re = pick_part(v.re_lo, v.re_hi);
            s.ex_im = pick_part(v.im_lo, v.im_hi);
         end
         MODE_Y: begin
            s.ey_re = pick_part(v.re_lo, v.re_hi);
            s.ey_im = pick_part(v.im_lo, v.im_hi);
         end
         MODE_Z: begin
            s.ez_re = pick_part(v.re_lo, v.re_hi);
            s.ez_im = pick_part(v.im_lo, v.im_hi);
         end
         default: begin
            s.ex_re = pick_power_part();
            s.ex_im = pick_power_part();
            s.ey_re = pick_power_part();
            s.ey_im = pick_power_part();
            s.ez_re = pick_power_part();
            s.ez_im = pick_power_part();
         end
      endcase
      return s;
   endfunction

   initial begin : stimulus
      view_settings_type v;
      req_chan.valid = 1'b0;
      req_chan.ex_re = '0;
      req_chan.ex_im = '0;
      req_chan.ey_re = '0;
      req_chan.ey_im = '0;
      req_chan.ez_re = '0;
      req_chan.ez_im = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: mid range, exact bounds, clamp above one, below zero
      send_sample(field_sample_type'{0, 0, 0, 0, 0, 0});
      send_sample(field_sample_type'{RST_LOW, RST_HIGH, Q_MAX, Q_MIN, 1, -1});
      send_sample(field_sample_type'{Q_MAX, Q_MIN, 0, 0, 0, 0});
      send_sample(field_sample_type'{50 * Q_ONE, -50 * Q_ONE, $urandom, $urandom, $urandom,
                                     $urandom});

      // Full-width real range, zero imaginary interval at zero
      drain_pipeline();
      v = '{MODE_Y, 2'b11, Q_MIN, Q_MAX, 0, 0, 24'hFFFFFF, 24'h808080};
      load_settings(v);
      send_sample(field_sample_type'{0, 0, Q_MIN, 0, 0, 0});
      send_sample(field_sample_type'{0, 0, Q_MAX, 1, 0, 0});
      send_sample(field_sample_type'{0, 0, 0, -1, 0, 0});

      // Reversed real interval, zero imaginary interval at the minimum
      drain_pipeline();
      v = '{MODE_Z, 2'b11, 100 * Q_ONE, -100 * Q_ONE, Q_MIN, Q_MIN, 24'h00FF00, 24'hFFFFFF};
      load_settings(v);
      send_sample(field_sample_type'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, Q_MIN});
      send_sample(field_sample_type'{0, 0, 0, 0, -200 * Q_ONE, Q_MAX});
      send_sample(field_sample_type'{0, 0, 0, 0, 200 * Q_ONE, Q_MIN + 1});

      // Intensity, imaginary part only: zero against -1..1, saturating sum
      drain_pipeline();
      v = '{MODE_INTENSITY, 2'b10, 0, Q_MAX, -1, 1, 24'h123456, 24'hFFFFFF};
      load_settings(v);
      send_sample(field_sample_type'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX});
      send_sample(field_sample_type'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN});
      send_sample(field_sample_type'{0, 0, 0, 0, 0, 0});

      // Intensity, real part only, against 0..1.0
      drain_pipeline();
      v = '{MODE_INTENSITY, 2'b01, 0, Q_ONE, RST_LOW, RST_HIGH, 24'hFFFFFF, 24'hFFFFFF};
      load_settings(v);
      send_sample(field_sample_type'{Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2,
                                     Q_ONE / 2});
      send_sample(field_sample_type'{Q_ONE / 4, 0, 0, 0, 0, -3});
      send_sample(field_sample_type'{0, 0, -(Q_ONE / 2), 0, Q_ONE / 4, 0});

      // Both parts masked off
      drain_pipeline();
      v = '{MODE_X, 2'b00, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 24'hFFFFFF, 24'hFFFFFF};
      load_settings(v);
      send_sample(field_sample_type'{Q_MAX, Q_MAX, 0, 0, 0, 0});
      send_sample(field_sample_type'{$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom});

      // Random phases, a fresh setting each
      for (int phase = 0; phase < 11; phase++) begin
         drain_pipeline();
         if (phase == 5) no_gaps <= 1'b1;
         if (phase == 6) no_gaps <= 1'b0;
         v = random_settings((phase < 4) ? mode_type'(phase) : mode_type'($urandom_range(3)));
         if (phase == 0) begin
            v.re_lo    = Q_MIN;
            v.re_hi    = Q_MAX;
            v.im_lo    = Q_MAX;
            v.im_hi    = Q_MIN;
            v.mask     = 2'b11;
            v.real_rgb = '1;
            v.imag_rgb = '1;
         end
         load_settings(v);
         if (phase == 2) backpressure_armed <= 1'b1;
         repeat (50) send_sample(random_sample(v));
      end

      // Let the pipeline empty, then watch for stray responses
      drain_pipeline();
      repeat (2 * PIPE_LAT) @(posedge clock);
      if (mismatches == 0) begin
         $display("complex_field_pixel_colorizer_test: PASS");
      end else begin
         $display("complex_field_pixel_colorizer_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: complex_field_pixel_colorizer.f
rtl/cfpc_pkg.sv
rtl/cfpc_channels.sv
rtl/cfpc_norm.sv
rtl/complex_field_pixel_colorizer.sv
tb/sv/cfpc_checker.sv
tb/sv/complex_field_pixel_colorizer_test.sv
